### rtl/bvh_pkg.sv
package bvh_pkg;

   // Field widths and storage sizes.
   localparam int COUNT_WIDTH     = 32;
   localparam int NUM_BINS        = 256;
   localparam int SYMBOL_WIDTH    = 8;
   localparam int OPCODE_WIDTH    = 2;
   localparam int OUT_WIDTH       = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Opcodes on the request port.
   localparam logic [OPCODE_WIDTH-1:0] OP_COUNT = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd2;

   // Largest bin value and largest value the result port can show.
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [63:0] OUT_MAX_WIDE = (64'd1 << OUT_WIDTH) - 64'd1;

   // Work kinds that the front hands to the back.
   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } item_kind_type;

   typedef struct packed {
      item_kind_type            kind;
      logic [SYMBOL_WIDTH-1:0]  symbol;
   } queue_entry_type;

   // Head of the queue as seen by the back.
   typedef struct packed {
      logic             valid;
      queue_entry_type  entry;
   } queue_head_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } back_state_type;

   // Clip a bin value to the width of the result port.
   function automatic logic [OUT_WIDTH-1:0] clip_count(input logic [COUNT_WIDTH-1:0] value);
      logic [63:0]           wide;
      logic [OUT_WIDTH-1:0]  result;
      wide = 64'(value);
      if (wide > OUT_MAX_WIDE) begin
         result = '1;
      end else begin
         result = OUT_WIDTH'(wide);
      end
      return result;
   endfunction

endpackage

### rtl/bvh_ram.sv
module bvh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bvh_front.sv
module bvh_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bvh_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    req_symbol,
   input  logic                                pop,
   output bvh_pkg::queue_head_type             head
);

   bvh_pkg::queue_entry_type                  entries_ff [bvh_pkg::QUEUE_DEPTH];
   logic [bvh_pkg::QUEUE_PTR_WIDTH-1:0]       head_ff, head_in;
   logic [bvh_pkg::QUEUE_PTR_WIDTH-1:0]       tail_ff, tail_in;
   logic [bvh_pkg::QUEUE_CNT_WIDTH-1:0]       fill_ff, fill_in;
   bvh_pkg::queue_entry_type                  new_entry;
   logic                                      keep;
   logic                                      push;
   logic                                      do_pop;

   // Classify the opcode; the unused code is dropped here.
   always_comb begin
      new_entry.symbol = req_symbol;
      new_entry.kind   = bvh_pkg::KIND_COUNT;
      keep             = 1'b1;
      unique case (req_opcode)
         bvh_pkg::OP_COUNT: new_entry.kind = bvh_pkg::KIND_COUNT;
         bvh_pkg::OP_READ:  new_entry.kind = bvh_pkg::KIND_READ;
         bvh_pkg::OP_CLEAR: new_entry.kind = bvh_pkg::KIND_CLEAR;
         default:           keep = 1'b0;
      endcase
   end

   assign busy   = (fill_ff == bvh_pkg::QUEUE_CNT_WIDTH'(bvh_pkg::QUEUE_DEPTH));
   assign push   = start && !busy && keep;
   assign do_pop = pop && (fill_ff != '0);

   // Pointer and fill count updates.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (push) begin
         if (tail_ff == bvh_pkg::QUEUE_PTR_WIDTH'(bvh_pkg::QUEUE_DEPTH - 1)) begin
            tail_in = '0;
         end else begin
            tail_in = tail_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (head_ff == bvh_pkg::QUEUE_PTR_WIDTH'(bvh_pkg::QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= new_entry;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.entry = entries_ff[head_ff];

endmodule

### rtl/bvh_back.sv
module bvh_back (
   input  logic                                clock,
   input  logic                                reset,
   input  bvh_pkg::queue_head_type             head,
   output logic                                pop,
   output logic                                rsp_strobe,
   output logic [bvh_pkg::SYMBOL_WIDTH-1:0]    rsp_bin_symbol,
   output logic [bvh_pkg::OUT_WIDTH-1:0]       rsp_occurrences,
   output logic                                rsp_present
);

   bvh_pkg::back_state_type                state_ff, state_in;
   bvh_pkg::item_kind_type                 kind_ff, kind_in;
   logic [bvh_pkg::SYMBOL_WIDTH-1:0]       sym_ff, sym_in;
   logic [bvh_pkg::NUM_BINS-1:0]           seen_ff, seen_in;
   logic                                   strobe_ff, strobe_in;
   logic [bvh_pkg::SYMBOL_WIDTH-1:0]       out_sym_ff;
   logic [bvh_pkg::OUT_WIDTH-1:0]          out_count_ff;
   logic                                   out_present_ff;
   logic                                   rd_en;
   logic                                   wr_en;
   logic [bvh_pkg::COUNT_WIDTH-1:0]        wr_data;
   logic [bvh_pkg::COUNT_WIDTH-1:0]        rd_data;
   logic                                   cur_seen;

   bvh_ram #(
      .WIDTH (bvh_pkg::COUNT_WIDTH),
      .DEPTH (bvh_pkg::NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sym_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head.entry.symbol),
      .rd_data (rd_data)
   );

   assign cur_seen = seen_ff[sym_ff];

   // Sequencer: take an item in idle; a clear finishes there, while counts and reads finish in the exec state.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      sym_in    = sym_ff;
      seen_in   = seen_ff;
      strobe_in = 1'b0;
      pop       = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_data   = rd_data + 1'b1;
      unique case (state_ff)
         bvh_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.kind == bvh_pkg::KIND_CLEAR) begin
                  seen_in = '0;
               end else begin
                  rd_en    = 1'b1;
                  kind_in  = head.entry.kind;
                  sym_in   = head.entry.symbol;
                  state_in = bvh_pkg::ST_EXEC;
               end
            end
         end
         bvh_pkg::ST_EXEC: begin
            state_in = bvh_pkg::ST_IDLE;
            if (kind_ff == bvh_pkg::KIND_COUNT) begin
               // A bin not yet seen starts at one; a seen bin stops at its maximum.
               if (!cur_seen) begin
                  wr_en           = 1'b1;
                  wr_data         = bvh_pkg::COUNT_WIDTH'(1);
                  seen_in[sym_ff] = 1'b1;
               end else if (rd_data != bvh_pkg::COUNT_MAX) begin
                  wr_en = 1'b1;
               end
            end else begin
               strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = bvh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bvh_pkg::ST_IDLE;
         seen_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         strobe_ff <= strobe_in;
      end
   end

   // Item registers and the result register carry payload only.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sym_ff  <= sym_in;
      if (strobe_in) begin
         out_sym_ff     <= sym_ff;
         out_present_ff <= cur_seen;
         out_count_ff   <= cur_seen ? bvh_pkg::clip_count(rd_data) : '0;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_bin_symbol  = out_sym_ff;
   assign rsp_occurrences = out_count_ff;
   assign rsp_present     = out_present_ff;

endmodule

### rtl/byte_value_histogram_unit.sv
// Byte histogram with 256 saturating bins. An item is taken at a clock edge
// where start is high and busy is low; busy rises only when the four-entry
// request queue is full. A count or a read occupies the bin engine for a bin
// memory read and then a write-back or result, and the engine takes no new
// item until it is done; a clear is done in the idle state, and the unused
// opcode is dropped at the input without using the engine. A burst of seven
// counts or reads enters back to back into an idle unit. A read goes through
// the request queue, the bin memory read and the result register before
// rsp_strobe rises; the result is shown for exactly one cycle with rsp_strobe
// high and cannot be held off by the receiver.
// Counts and clears produce no result.
module byte_value_histogram_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bvh_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    req_symbol,
   output logic                                rsp_strobe,
   output logic [bvh_pkg::SYMBOL_WIDTH-1:0]    rsp_bin_symbol,
   output logic [bvh_pkg::OUT_WIDTH-1:0]       rsp_occurrences,
   output logic                                rsp_present
);

   bvh_pkg::queue_head_type  head;
   logic                     pop;

   // Input side: accept, classify and queue items.
   bvh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_symbol (req_symbol),
      .pop        (pop),
      .head       (head)
   );

   // Bin engine: update bins and answer reads.
   bvh_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_bin_symbol  (rsp_bin_symbol),
      .rsp_occurrences (rsp_occurrences),
      .rsp_present     (rsp_present)
   );

endmodule

### rtl/bvh_checker.sv
module bvh_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [bvh_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    req_symbol,
   input  logic                                rsp_strobe,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    rsp_bin_symbol,
   input  logic [bvh_pkg::OUT_WIDTH-1:0]       rsp_occurrences,
   input  logic                                rsp_present
);

   // After reset the queue is empty and no result is pending.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("result or busy right after reset");

   // A bin that was not seen reports a zero count.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_present |-> rsp_occurrences == '0)
      else $error("absent bin with nonzero count");

   // A seen bin holds at least one occurrence.
   a_present_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_present |-> rsp_occurrences != '0)
      else $error("present bin with zero count");

   // Two results are never shown back to back.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   // A result needs a request that went through the queue and the bin engine after reset.
   a_result_after_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(reset, 1) && !$past(reset, 2))
      else $error("result too soon after reset");

endmodule

bind byte_value_histogram_unit bvh_checker u_checker (.*);

### tb/sv/byte_value_histogram_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the histogram unit, keeps its own copy of the
// bins and the seen map, and compares every bin report with the oldest read
// that is still waiting for one.
module byte_value_histogram_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [bvh_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    req_symbol,
   input  logic                                rsp_strobe,
   input  logic [bvh_pkg::SYMBOL_WIDTH-1:0]    rsp_bin_symbol,
   input  logic [bvh_pkg::OUT_WIDTH-1:0]       rsp_occurrences,
   input  logic                                rsp_present,
   output int                                  mismatch_count,
   output int                                  pending_reads,
   output int                                  checked_reads
);

   import bvh_pkg::*;

   typedef struct packed {
      logic [SYMBOL_WIDTH-1:0]  symbol;
      logic [OUT_WIDTH-1:0]     occurrences;
      logic                     present;
   } bin_report_type;

   logic [COUNT_WIDTH-1:0]  bin_tally [NUM_BINS];
   logic                    bin_seen  [NUM_BINS];
   bin_report_type          expected_reports [$];

   // A bin wider than the result port shows as all ones once it overflows it.
   function automatic logic [OUT_WIDTH-1:0] visible_count(input logic [COUNT_WIDTH-1:0] tally);
      logic [63:0] wide;
      wide = 64'(tally);
      if ((wide >> OUT_WIDTH) != 64'd0) begin
         return '1;
      end
      return OUT_WIDTH'(wide);
   endfunction

   task automatic report_mismatch(input string detail);
      $display("Mismatch at %0t: %s", $time, detail);
      mismatch_count++;
   endtask

   // Update the bins for one accepted item; a read queues the report it must produce.
   task automatic apply_item(input logic [OPCODE_WIDTH-1:0] op,
                             input logic [SYMBOL_WIDTH-1:0] sym);
      bin_report_type report;
      case (op)
         OP_COUNT: begin
            if (!bin_seen[sym]) begin
               bin_tally[sym] = COUNT_WIDTH'(1);
               bin_seen[sym]  = 1'b1;
            end else if (bin_tally[sym] != {COUNT_WIDTH{1'b1}}) begin
               bin_tally[sym] = bin_tally[sym] + 1'b1;
            end
         end
         OP_READ: begin
            report.symbol      = sym;
            report.present     = bin_seen[sym];
            report.occurrences = bin_seen[sym] ? visible_count(bin_tally[sym]) : '0;
            expected_reports.insert(expected_reports.size(), report);
         end
         OP_CLEAR: begin
            for (int b = 0; b < NUM_BINS; b++) begin
               bin_seen[b] = 1'b0;
            end
         end
         default: begin
            // The unused opcode leaves everything as it was.
         end
      endcase
   endtask

   // Compare one bin report against the oldest waiting read.
   task automatic check_report();
      bin_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch($sformatf("bin report for symbol %0h with no read waiting",
                                   rsp_bin_symbol));
      end else begin
         want = expected_reports.pop_front();
         checked_reads++;
         if (rsp_bin_symbol !== want.symbol) begin
            report_mismatch($sformatf("bin_symbol expected %0h got %0h",
                                      want.symbol, rsp_bin_symbol));
         end
         if (rsp_occurrences !== want.occurrences) begin
            report_mismatch($sformatf("occurrences of %0h expected %0d got %0d",
                                      want.symbol, want.occurrences, rsp_occurrences));
         end
         if (rsp_present !== want.present) begin
            report_mismatch($sformatf("present of %0h expected %0b got %0b",
                                      want.symbol, want.present, rsp_present));
         end
      end
   endtask

   // Results are taken before the item of the same edge; a result never
   // belongs to an item accepted in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BINS; b++) begin
            bin_seen[b]  = 1'b0;
            bin_tally[b] = '0;
         end
         expected_reports.delete();
         mismatch_count = 0;
         checked_reads  = 0;
      end else begin
         if (rsp_strobe !== 1'b0) begin
            check_report();
         end
         if (start && !busy) begin
            apply_item(req_opcode, req_symbol);
         end
      end
      pending_reads <= expected_reports.size();
   end

endmodule

### tb/sv/byte_value_histogram_unit_test.sv
`timescale 1ns / 1ps

module byte_value_histogram_unit_test;

   import bvh_pkg::*;

   localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASE_COUNT  = 9;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 500000;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       start      = 1'b0;
   logic [OPCODE_WIDTH-1:0]    req_opcode = OP_COUNT;
   logic [SYMBOL_WIDTH-1:0]    req_symbol = '0;
   logic                       busy;
   logic                       rsp_strobe;
   logic [SYMBOL_WIDTH-1:0]    rsp_bin_symbol;
   logic [OUT_WIDTH-1:0]       rsp_occurrences;
   logic                       rsp_present;

   int mismatch_count;
   int pending_reads;
   int checked_reads;

   int  cycle_count = 0;
   int  n_count, n_read, n_clear, n_unused;
   bit  gaps_on;
   bit  ever_written [NUM_BINS];
   logic [SYMBOL_WIDTH-1:0] hot_pool [4];

   byte_value_histogram_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .rsp_strobe      (rsp_strobe),
      .rsp_bin_symbol  (rsp_bin_symbol),
      .rsp_occurrences (rsp_occurrences),
      .rsp_present     (rsp_present)
   );

   byte_value_histogram_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .rsp_strobe      (rsp_strobe),
      .rsp_bin_symbol  (rsp_bin_symbol),
      .rsp_occurrences (rsp_occurrences),
      .rsp_present     (rsp_present),
      .mismatch_count  (mismatch_count),
      .pending_reads   (pending_reads),
      .checked_reads   (checked_reads)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the unit hangs or drops a result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, now and then a long one.
   task automatic idle_after();
      int pick;
      int gap;
      pick = $urandom_range(99);
      gap  = 0;
      if (gaps_on) begin
         if (pick >= 93) begin
            gap = $urandom_range(40, 8);
         end else if (pick >= 65) begin
            gap = $urandom_range(3, 1);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Offer one item and hold it until the unit takes it. A read aimed at a bin
   // that has never held a count is turned into a count of that byte, so that
   // stale storage is never looked at.
   task automatic send_item(input logic [OPCODE_WIDTH-1:0] op,
                            input logic [SYMBOL_WIDTH-1:0] sym);
      logic [OPCODE_WIDTH-1:0] op_sent;
      op_sent = op;
      if (op == OP_READ && !ever_written[sym]) begin
         op_sent = OP_COUNT;
      end
      start      <= 1'b1;
      req_opcode <= op_sent;
      req_symbol <= sym;
      do @(posedge clock); while (busy);
      case (op_sent)
         OP_COUNT: begin
            n_count++;
            ever_written[sym] = 1'b1;
         end
         OP_READ:  n_read++;
         OP_CLEAR: n_clear++;
         default:  n_unused++;
      endcase
      idle_after();
   endtask

   // Stop sending until every read has been answered.
   task automatic wait_for_reads();
      start <= 1'b0;
      @(posedge clock);
      while (pending_reads != 0) @(posedge clock);
   endtask

   // Half the traffic lands on a few hot bytes so their bins grow large.
   function automatic logic [SYMBOL_WIDTH-1:0] pick_symbol();
      if ($urandom_range(1) == 1) begin
         return hot_pool[$urandom_range(3)];
      end
      return SYMBOL_WIDTH'($urandom_range(255));
   endfunction

   initial begin
      int sent;
      int pick;
      logic [SYMBOL_WIDTH-1:0] sym;

      for (int b = 0; b < NUM_BINS; b++) begin
         ever_written[b] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items, back to back: extreme bytes, consecutive counts of one
      // bin, the unused opcode, reads after a clear
      // and the first count after a clear.
      gaps_on = 1'b0;
      send_item(OP_COUNT, 8'h00);
      send_item(OP_COUNT, 8'hFF);
      send_item(OP_COUNT, 8'hFF);
      send_item(OP_READ,  8'h00);
      send_item(OP_READ,  8'hFF);
      send_item(OP_COUNT, 8'h80);
      send_item(OP_COUNT, 8'h01);
      send_item(OP_READ,  8'h80);
      send_item(OP_READ,  8'h01);
      send_item(OP_COUNT, 8'hA5);
      send_item(OP_COUNT, 8'hA5);
      send_item(OP_COUNT, 8'hA5);
      send_item(OP_READ,  8'hA5);
      send_item(OP_COUNT, 8'h5A);
      send_item(OP_UNUSED, 8'h5A);
      send_item(OP_READ,  8'h5A);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_READ,  8'hFF);
      send_item(OP_READ,  8'h5A);
      send_item(OP_COUNT, 8'hFF);
      send_item(OP_READ,  8'hFF);
      send_item(OP_COUNT, 8'h7F);
      send_item(OP_READ,  8'h7F);
      wait_for_reads();

      // Random phases, each with its own hot bytes; one phase in three runs
      // without gaps, and every phase ends by letting all reads come back.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         gaps_on = (phase % 3) != 1;
         for (int h = 0; h < 4; h++) begin
            hot_pool[h] = SYMBOL_WIDTH'($urandom_range(255));
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(199);
            sym  = pick_symbol();
            if (pick < 2) begin
               send_item(OP_CLEAR, sym);
               sent++;
            end else if (pick < 10) begin
               send_item(OP_UNUSED, sym);
            end else if (pick < 70) begin
               send_item(OP_READ, sym);
               sent++;
            end else begin
               send_item(OP_COUNT, sym);
               sent++;
            end
         end
         wait_for_reads();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d counts, %0d reads, %0d clears and %0d unused opcodes.",
               n_count, n_read, n_clear, n_unused);
      $display("Checked %0d bin reports over %0d cycles.", checked_reads, cycle_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### byte_value_histogram_unit.f
rtl/bvh_pkg.sv
rtl/bvh_ram.sv
rtl/bvh_front.sv
rtl/bvh_back.sv
rtl/byte_value_histogram_unit.sv
rtl/bvh_checker.sv
tb/sv/byte_value_histogram_checker.sv
tb/sv/byte_value_histogram_unit_test.sv
